FILE: rtl/core/nvpd_pkg.sv
// Shared types and constants for the name-value pair decoder.
package nvpd_pkg;

  localparam int unsigned LEN_W  = 31;
  localparam int unsigned BYTE_W = 8;

  localparam logic [1:0] KIND_LENGTH = 2'd0;
  localparam logic [1:0] KIND_NAME   = 2'd1;
  localparam logic [1:0] KIND_VALUE  = 2'd2;

  typedef enum logic [2:0] {
    PH_NLEN      = 3'd0,
    PH_NLEN_MORE = 3'd1,
    PH_VLEN      = 3'd2,
    PH_VLEN_MORE = 3'd3,
    PH_NAME      = 3'd4,
    PH_VALUE     = 3'd5
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data;
    logic              done;
    logic [LEN_W-1:0]  name_len;
    logic [LEN_W-1:0]  value_len;
    logic              trunc;
  } result_t;

endpackage

FILE: rtl/core/nvpd_in_stage.sv
// Input register that holds one request until the parser takes it.
module nvpd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  nvpd_pkg::in_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output nvpd_pkg::in_item_t item
);
  import nvpd_pkg::*;

  logic accept;

  assign in_stall = item_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

FILE: rtl/core/nvpd_parser.sv
// Parse state and the combinational step that decodes one content byte.
module nvpd_parser #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  nvpd_pkg::in_item_t item,
  output nvpd_pkg::result_t  result
);
  import nvpd_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  phase_t                 phase, phase_next;
  logic [1:0]             lbc, lbc_next;
  logic [LEN_W-1:0]       name_len, name_len_next;
  logic [LEN_W-1:0]       value_len, value_len_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;

  logic [LEN_W-1:0]       acc;
  logic [LEN_W-1:0]       acc_sat;
  logic [LEN_W-1:0]       body_value;
  logic                   body_start;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [1:0]             kind;
  logic                   done;
  logic                   trunc;

  always_comb begin
    // The extended-length accumulator serves both name and value lengths.
    if (phase == PH_VLEN_MORE) begin
      acc = {value_len[LEN_W-BYTE_W-1:0], item.data};
    end else begin
      acc = {name_len[LEN_W-BYTE_W-1:0], item.data};
    end
    acc_sat = (acc > LEN_MAX) ? LEN_MAX : acc;
    rem_dec = (remaining != '0) ? remaining - 1'b1 : remaining;

    phase_next     = phase;
    lbc_next       = lbc;
    name_len_next  = name_len;
    value_len_next = value_len;
    remaining_next = remaining;
    kind           = KIND_LENGTH;
    done           = 1'b0;
    body_start     = 1'b0;
    body_value     = value_len;

    unique case (phase)
      PH_NLEN_MORE: begin
        lbc_next = lbc + 2'd1;
        if (lbc == 2'd2) begin
          name_len_next = acc_sat;
          lbc_next      = 2'd0;
          phase_next    = PH_VLEN;
        end else begin
          name_len_next = acc;
        end
      end
      PH_VLEN: begin
        lbc_next = 2'd0;
        if (item.data[BYTE_W-1]) begin
          value_len_next = {{(LEN_W-BYTE_W+1){1'b0}}, item.data[BYTE_W-2:0]};
          phase_next     = PH_VLEN_MORE;
        end else begin
          value_len_next = {{(LEN_W-BYTE_W){1'b0}}, item.data};
          body_value     = value_len_next;
          body_start     = 1'b1;
        end
      end
      PH_VLEN_MORE: begin
        lbc_next = lbc + 2'd1;
        if (lbc == 2'd2) begin
          value_len_next = acc_sat;
          lbc_next       = 2'd0;
          body_value     = acc_sat;
          body_start     = 1'b1;
        end else begin
          value_len_next = acc;
        end
      end
      PH_NAME: begin
        kind = KIND_NAME;
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          if (value_len != '0) begin
            phase_next     = PH_VALUE;
            remaining_next = value_len[LENGTH_BITS-1:0];
          end else begin
            done = 1'b1;
          end
        end
      end
      PH_VALUE: begin
        kind = KIND_VALUE;
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          done = 1'b1;
        end
      end
      default: begin
        // The start phase: first byte of the name length.
        value_len_next = '0;
        lbc_next       = 2'd0;
        if (item.data[BYTE_W-1]) begin
          name_len_next = {{(LEN_W-BYTE_W+1){1'b0}}, item.data[BYTE_W-2:0]};
          phase_next    = PH_NLEN_MORE;
        end else begin
          name_len_next = {{(LEN_W-BYTE_W){1'b0}}, item.data};
          phase_next    = PH_VLEN;
        end
      end
    endcase

    // Both lengths known: go to the name, the value, or finish an empty pair.
    if (body_start) begin
      if (name_len != '0) begin
        phase_next     = PH_NAME;
        remaining_next = name_len[LENGTH_BITS-1:0];
      end else if (body_value != '0) begin
        phase_next     = PH_VALUE;
        remaining_next = body_value[LENGTH_BITS-1:0];
      end else begin
        done = 1'b1;
      end
    end

    if (done) begin
      phase_next     = PH_NLEN;
      lbc_next       = 2'd0;
      remaining_next = '0;
    end

    trunc = item.last && !done;

    result.kind      = kind;
    result.data      = item.data;
    result.done      = done;
    result.name_len  = name_len_next;
    result.value_len = value_len_next;
    result.trunc     = trunc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NLEN;
      lbc       <= 2'd0;
      name_len  <= '0;
      value_len <= '0;
      remaining <= '0;
    end else if (fire) begin
      if (trunc) begin
        // Content ended inside a pair: start over for the next record.
        phase     <= PH_NLEN;
        lbc       <= 2'd0;
        name_len  <= '0;
        value_len <= '0;
        remaining <= '0;
      end else begin
        phase     <= phase_next;
        lbc       <= lbc_next;
        name_len  <= name_len_next;
        value_len <= value_len_next;
        remaining <= remaining_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_trunc_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && result.trunc |=> phase == PH_NLEN && name_len == '0)
    else $error("parser did not restart after truncated content");

  a_done_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && result.done |=> phase == PH_NLEN && remaining == '0)
    else $error("parser did not return to start after a finished pair");

  a_body_nonempty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NAME || phase == PH_VALUE) |-> remaining != '0)
    else $error("name or value phase with no bytes remaining");

  a_count_in_ext: assert property (@(posedge clk) disable iff (rst)
    lbc != 2'd0 |-> (phase == PH_NLEN_MORE || phase == PH_VLEN_MORE))
    else $error("length byte count set outside an extended length");
`endif

endmodule

FILE: rtl/core/nvpd_out_stage.sv
// Result register that holds one decoded byte until downstream takes it.
module nvpd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  nvpd_pkg::result_t result,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output nvpd_pkg::result_t held
);
  import nvpd_pkg::*;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

FILE: rtl/core/name_value_pair_decoder.sv
// A byte is held in the input register, parsed, and its result registered in the output stage.
// Throughput: one byte per cycle while the output is not stalled; the parse state updates once per byte.
// The input register accepts a new byte while a finished result waits at the output.
// Reset clears both stage valids and puts the parser in its start phase with zero lengths.
// Truncated content also returns the parser to that start state.
module name_value_pair_decoder #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  byte_kind,
  output logic [7:0]  data_out,
  output logic        pair_done,
  output logic [30:0] name_length,
  output logic [30:0] value_length,
  output logic        truncated
);
  import nvpd_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     out_ready;
  logic     fire;
  result_t  result;
  result_t  held;

  assign in_item.data = data_byte;
  assign in_item.last = last_byte;
  assign fire = item_valid && out_ready;

  nvpd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  nvpd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  nvpd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .result    (result),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (held)
  );

  assign byte_kind    = held.kind;
  assign data_out     = held.data;
  assign pair_done    = held.done;
  assign name_length  = held.name_len;
  assign value_length = held.value_len;
  assign truncated    = held.trunc;

endmodule

FILE: bench/nvpd_checker.sv
// Checker for the name-value pair decoder: predicts each tagged byte and compares the outputs.
module nvpd_checker #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  byte_kind,
  input  logic [7:0]  data_out,
  input  logic        pair_done,
  input  logic [30:0] name_length,
  input  logic [30:0] value_length,
  input  logic        truncated,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import nvpd_pkg::*;

  localparam logic [31:0] LEN_CEIL = 32'((64'd1 << LENGTH_BITS) - 64'd1);

  phase_t           phase;
  logic [1:0]       extra_seen;
  logic [LEN_W-1:0] name_held;
  logic [LEN_W-1:0] value_held;
  logic [LEN_W-1:0] left_to_go;
  result_t          bytes_due[$];

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    if (32'(v) > LEN_CEIL) return LEN_CEIL[LEN_W-1:0];
    return v;
  endfunction

  function automatic void clear_parser();
    phase = PH_NLEN;
    extra_seen = '0;
    name_held = '0;
    value_held = '0;
    left_to_go = '0;
  endfunction

  // Both lengths are known here; a pair with no body bytes completes at once.
  function automatic logic enter_body();
    if (name_held != '0) begin
      phase = PH_NAME;
      left_to_go = name_held;
      return 1'b0;
    end
    if (value_held != '0) begin
      phase = PH_VALUE;
      left_to_go = value_held;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b, input logic l);
    result_t    r;
    logic       done;
    logic [1:0] kind;
    done = 1'b0;
    kind = KIND_LENGTH;
    case (phase)
      PH_NLEN: begin
        value_held = '0;
        extra_seen = '0;
        if (b[7]) begin
          name_held = LEN_W'(b[6:0]);
          phase = PH_NLEN_MORE;
        end else begin
          name_held = clamp_len(LEN_W'(b));
          phase = PH_VLEN;
        end
      end
      PH_NLEN_MORE: begin
        name_held = {name_held[LEN_W-9:0], b};
        extra_seen = extra_seen + 2'd1;
        if (extra_seen == 2'd3) begin
          name_held = clamp_len(name_held);
          extra_seen = '0;
          phase = PH_VLEN;
        end
      end
      PH_VLEN: begin
        extra_seen = '0;
        if (b[7]) begin
          value_held = LEN_W'(b[6:0]);
          phase = PH_VLEN_MORE;
        end else begin
          value_held = clamp_len(LEN_W'(b));
          done = enter_body();
        end
      end
      PH_VLEN_MORE: begin
        value_held = {value_held[LEN_W-9:0], b};
        extra_seen = extra_seen + 2'd1;
        if (extra_seen == 2'd3) begin
          value_held = clamp_len(value_held);
          extra_seen = '0;
          done = enter_body();
        end
      end
      PH_NAME: begin
        kind = KIND_NAME;
        if (left_to_go != '0) left_to_go = left_to_go - 1'b1;
        if (left_to_go == '0) begin
          if (value_held != '0) begin
            phase = PH_VALUE;
            left_to_go = value_held;
          end else begin
            done = 1'b1;
          end
        end
      end
      default: begin
        kind = KIND_VALUE;
        if (left_to_go != '0) left_to_go = left_to_go - 1'b1;
        if (left_to_go == '0) done = 1'b1;
      end
    endcase
    if (done) begin
      phase = PH_NLEN;
      extra_seen = '0;
      left_to_go = '0;
    end
    r.kind = kind;
    r.data = b;
    r.done = done;
    r.name_len = name_held;
    r.value_len = value_held;
    r.trunc = l && !done;
    // Content that ends inside a pair throws the parser back to its start state.
    if (r.trunc) clear_parser();
    return r;
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst) begin
      clear_parser();
      bytes_due.delete();
      mismatches = 0;
    end else begin
      // Compare before predicting so a stray result never meets this edge's request.
      if (out_valid && !out_stall) begin
        seen.kind = byte_kind;
        seen.data = data_out;
        seen.done = pair_done;
        seen.name_len = name_length;
        seen.value_len = value_length;
        seen.trunc = truncated;
        if (bytes_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: kind %0d data %02h done %0b name %0d value %0d trunc %0b",
                     seen.kind, seen.data, seen.done, seen.name_len, seen.value_len,
                     seen.trunc);
          mismatches = mismatches + 1;
        end else begin
          want = bytes_due.pop_front();
          if (seen != want) begin
            if (mismatches < 10) begin
              $display("mismatch: expected kind %0d data %02h done %0b name %0d value %0d trunc %0b",
                       want.kind, want.data, want.done, want.name_len, want.value_len,
                       want.trunc);
              $display("          actual   kind %0d data %02h done %0b name %0d value %0d trunc %0b",
                       seen.kind, seen.data, seen.done, seen.name_len, seen.value_len,
                       seen.trunc);
            end
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) bytes_due.push_back(parse_byte(data_byte, last_byte));
    end
    pending <= bytes_due.size();
  end

endmodule

FILE: bench/name_value_pair_decoder_test.sv
// Top of the name-value pair decoder bench: clock, reset, byte streams, receiver and verdict.
module name_value_pair_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  byte_kind;
  logic [7:0]  data_out;
  logic        pair_done;
  logic [30:0] name_length;
  logic [30:0] value_length;
  logic        truncated;
  int          mismatches;
  int          pending;
  int          sent_bytes = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  name_value_pair_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_kind    (byte_kind),
    .data_out     (data_out),
    .pair_done    (pair_done),
    .name_length  (name_length),
    .value_length (value_length),
    .truncated    (truncated)
  );

  nvpd_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_kind    (byte_kind),
    .data_out     (data_out),
    .pair_done    (pair_done),
    .name_length  (name_length),
    .value_length (value_length),
    .truncated    (truncated),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off each time hold_req toggles.
  initial begin
    bit hold_seen;
    int hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 23);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic l);
    while (!quiet && ($urandom_range(99) < 23)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_record(ref byte_q_t rec, input int cut);
    for (int i = 0; i <= cut; i++) push_byte(rec[i], i == cut);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [30:0] pick_len();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 20) return '0;
    if (sel < 75) return 31'($urandom_range(6, 1));
    if (sel < 95) return 31'($urandom_range(24, 7));
    return 31'($urandom_range(127, 25));
  endfunction

  task automatic add_len(ref byte_q_t rec, input logic [30:0] len, input bit wide);
    if (wide || len > 31'd127) begin
      rec.push_back({1'b1, len[30:24]});
      rec.push_back(len[23:16]);
      rec.push_back(len[15:8]);
      rec.push_back(len[7:0]);
    end else begin
      rec.push_back({1'b0, len[6:0]});
    end
  endtask

  // A huge pair carries a random 31-bit length and only a few body bytes,
  // so it is only used where the record is cut short.
  task automatic add_pair(ref byte_q_t rec, input bit huge);
    logic [30:0] nlen;
    logic [30:0] vlen;
    int          body;
    nlen = pick_len();
    vlen = pick_len();
    if (huge) begin
      if ($urandom_range(1) == 1) nlen = 31'($urandom);
      else vlen = 31'($urandom);
      body = $urandom_range(8, 0);
    end else begin
      body = int'(nlen) + int'(vlen);
    end
    add_len(rec, nlen, $urandom_range(99) < 25);
    add_len(rec, vlen, $urandom_range(99) < 25);
    repeat (body) rec.push_back(8'($urandom));
  endtask

  initial begin
    byte_q_t rec;
    int      sel;
    bit      hold_done;
    bit      pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    data_byte <= '0;
    last_byte <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty name and value: the pair closes on its value length byte.
    rec = {8'h00, 8'h00};
    send_record(rec, rec.size() - 1);
    // Content that ends on the first length byte of a pair.
    push_byte(8'h05, 1'b1);
    // Empty value closes on the last name byte; empty name skips to the value.
    rec = {8'h01, 8'h00, 8'h41};
    send_record(rec, rec.size() - 1);
    rec = {8'h00, 8'h01, 8'hbe};
    send_record(rec, rec.size() - 1);
    // Four-byte lengths: a zero name and a value of two bytes.
    rec = {8'h80, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h02, 8'h5a, 8'ha5};
    send_record(rec, rec.size() - 1);
    // Largest name length, cut off on the value length byte.
    rec = {8'hff, 8'hff, 8'hff, 8'hff, 8'h7f};
    send_record(rec, rec.size() - 1);

    while (sent_bytes < 1900) begin
      rec.delete();
      if (!hold_done && sent_bytes >= 200) begin
        hold_req = ~hold_req;
        hold_done = 1'b1;
      end
      if (!pause_done && sent_bytes >= 700) begin
        drain_results();
        pause_done = 1'b1;
      end
      quiet = (sent_bytes >= 1100) && (sent_bytes < 1450);
      sel = $urandom_range(99);
      if (sel < 75) begin
        repeat ($urandom_range(4, 1)) add_pair(rec, 1'b0);
        send_record(rec, rec.size() - 1);
      end else if (sel < 90) begin
        repeat ($urandom_range(2, 1)) add_pair(rec, $urandom_range(1) == 1);
        send_record(rec, $urandom_range(rec.size() - 1, 0));
      end else begin
        repeat ($urandom_range(8, 1)) rec.push_back(8'($urandom));
        foreach (rec[i]) push_byte(rec[i], $urandom_range(3) == 0);
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
